>>> hw/rtl/cidf_pkg.sv
`timescale 1ns / 1ps

package cidf_pkg;

	localparam int ENTRIES = 16;
	localparam int IDX_W   = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
	localparam int ID_W    = 29;

	localparam logic [IDX_W-1:0] IDX_LAST = IDX_W'(ENTRIES - 1);

	localparam logic [1:0] KIND_CHECK  = 2'd0;
	localparam logic [1:0] KIND_ADD    = 2'd1;
	localparam logic [1:0] KIND_REMOVE = 2'd2;

	typedef struct packed {
		logic [1:0]      kind;
		logic [ID_W-1:0] ident;
		logic [ID_W-1:0] mask;
		logic            extended;
		logic            is_message;
	} in_item_t;

	typedef struct packed {
		logic forward;
		logic add_refused;
	} out_item_t;

	typedef struct packed {
		logic            ext;
		logic [ID_W-1:0] mask;
		logic [ID_W-1:0] ident;
	} entry_t;

	localparam int ENTRY_W = $bits(entry_t);

endpackage

>>> hw/rtl/cidf_in_if.sv
`timescale 1ns / 1ps

interface cidf_in_if;
	logic               valid;
	logic               ready;
	cidf_pkg::in_item_t data;

	modport source (output valid, output data, input ready);
	modport sink   (input valid, input data, output ready);
endinterface

>>> hw/rtl/cidf_out_if.sv
`timescale 1ns / 1ps

interface cidf_out_if;
	logic                valid;
	logic                ready;
	cidf_pkg::out_item_t data;

	modport source (output valid, output data, input ready);
	modport sink   (input valid, input data, output ready);
endinterface

>>> hw/rtl/can_id_mask_reject_filter_top.sv
`timescale 1ns / 1ps

// Channel  Dir  Payload                                    Handshake
// req      in   kind, ident, mask, extended, is_message    valid/ready
// rsp      out  forward, add_refused                       valid/ready
//
// One item at a time; req.ready is high only while the sequencer is idle.
// Check and remove walk the table one entry per cycle through the RAM read
// port. Add walks the valid bits up to the first free entry. An unused kind
// and a non-message check skip the scan and go straight to the finish state.
// Reset clears all valid bits at once; no clearing pass.
// A result waits in the output register; a stalled rsp holds the next result.

module can_id_mask_reject_filter_top (
	input  logic              clk,
	input  logic              arst_n,
	cidf_in_if.sink           req,
	cidf_out_if.source        rsp
);

	typedef enum logic [3:0] {
		ST_IDLE   = 4'b0001,
		ST_SCAN   = 4'b0010,
		ST_DRAIN  = 4'b0100,
		ST_FINISH = 4'b1000
	} state_t;

	state_t                           state_q;
	cidf_pkg::in_item_t               item_q;
	logic [cidf_pkg::IDX_W-1:0]       idx_q;
	logic [cidf_pkg::IDX_W-1:0]       idx_s1;
	logic                             vld_s1;
	logic [cidf_pkg::ENTRIES-1:0]     valid_q;
	logic                             hit_q;
	logic                             refused_q;
	logic                             out_vld_q;
	cidf_pkg::out_item_t              out_q;

	logic                             in_acc;
	logic                             fin_load;
	logic                             is_add;
	logic                             ram_we;
	logic                             ram_re;
	logic [cidf_pkg::ENTRY_W-1:0]     ram_rdata;
	cidf_pkg::entry_t                 key;
	cidf_pkg::entry_t                 ent;
	logic                             chk_hit;
	logic                             rm_hit;

	assign in_acc   = (state_q == ST_IDLE) && req.valid;
	assign fin_load = (state_q == ST_FINISH) && (!out_vld_q || rsp.ready);
	assign is_add   = (item_q.kind == cidf_pkg::KIND_ADD);

	assign key.ext   = item_q.extended;
	assign key.mask  = item_q.mask;
	assign key.ident = item_q.ident;

	assign ram_we = (state_q == ST_SCAN) && is_add && !valid_q[idx_q];
	assign ram_re = (state_q == ST_SCAN) && !is_add;

	cidf_ram #(
		.WIDTH(cidf_pkg::ENTRY_W),
		.DEPTH(cidf_pkg::ENTRIES)
	) u_table (
		.clk  (clk),
		.we   (ram_we),
		.waddr(idx_q),
		.wdata(key),
		.re   (ram_re),
		.raddr(idx_q),
		.rdata(ram_rdata)
	);

	assign ent = cidf_pkg::entry_t'(ram_rdata);

	assign chk_hit = vld_s1 && valid_q[idx_s1] && (item_q.kind == cidf_pkg::KIND_CHECK)
		&& (ent.ext == item_q.extended) && ((item_q.ident & ent.mask) == ent.ident);
	assign rm_hit  = vld_s1 && valid_q[idx_s1] && (item_q.kind == cidf_pkg::KIND_REMOVE)
		&& (ent == key);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= ST_IDLE;
			idx_q     <= '0;
			vld_s1    <= 1'b0;
			valid_q   <= '0;
			hit_q     <= 1'b0;
			refused_q <= 1'b0;
			out_vld_q <= 1'b0;
		end else begin
			if (fin_load) begin
				out_vld_q <= 1'b1;
			end else if (rsp.ready) begin
				out_vld_q <= 1'b0;
			end
			if (chk_hit) begin
				hit_q <= 1'b1;
			end
			if (rm_hit) begin
				valid_q[idx_s1] <= 1'b0;
			end
			unique case (state_q)
				ST_IDLE: begin
					if (in_acc) begin
						idx_q     <= '0;
						hit_q     <= 1'b0;
						refused_q <= 1'b0;
						if ((req.data.kind == cidf_pkg::KIND_ADD)
							|| (req.data.kind == cidf_pkg::KIND_REMOVE)
							|| ((req.data.kind == cidf_pkg::KIND_CHECK)
							&& req.data.is_message)) begin
							state_q <= ST_SCAN;
						end else begin
							state_q <= ST_FINISH;
						end
					end
				end
				ST_SCAN: begin
					if (is_add) begin
						if (!valid_q[idx_q]) begin
							valid_q[idx_q] <= 1'b1;
							state_q        <= ST_FINISH;
						end else if (idx_q == cidf_pkg::IDX_LAST) begin
							refused_q <= 1'b1;
							state_q   <= ST_FINISH;
						end else begin
							idx_q <= idx_q + 1'b1;
						end
					end else begin
						vld_s1 <= 1'b1;
						if (idx_q == cidf_pkg::IDX_LAST) begin
							state_q <= ST_DRAIN;
						end else begin
							idx_q <= idx_q + 1'b1;
						end
					end
				end
				ST_DRAIN: begin
					vld_s1  <= 1'b0;
					state_q <= ST_FINISH;
				end
				ST_FINISH: begin
					if (fin_load) begin
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (in_acc) begin
			item_q <= req.data;
		end
		if (state_q == ST_SCAN) begin
			idx_s1 <= idx_q;
		end
		if (fin_load) begin
			out_q.forward     <= (item_q.kind == cidf_pkg::KIND_CHECK) ? !hit_q : 1'b1;
			out_q.add_refused <= is_add && refused_q;
		end
	end

	assign req.ready = (state_q == ST_IDLE);
	assign rsp.valid = out_vld_q;
	assign rsp.data  = out_q;

	a_we_only_add: assert property (@(posedge clk) disable iff (!arst_n)
		ram_we |-> (state_q == ST_SCAN) && is_add)
		else $error("table write outside an add scan");

	a_s1_in_scan: assert property (@(posedge clk) disable iff (!arst_n)
		vld_s1 |-> (state_q == ST_SCAN) || (state_q == ST_DRAIN))
		else $error("compare stage active outside scan");

	a_out_from_finish: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_vld_q) |-> $past(state_q == ST_FINISH))
		else $error("result loaded outside finish");

	a_refuse_full: assert property (@(posedge clk) disable iff (!arst_n)
		($rose(out_vld_q) && out_q.add_refused) |-> (&valid_q))
		else $error("add refused while a free entry exists");

endmodule

>>> hw/rtl/cidf_ram.sv
`timescale 1ns / 1ps

module cidf_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  logic                                     clk,
	input  logic                                     we,
	input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
	input  logic [WIDTH-1:0]                         wdata,
	input  logic                                     re,
	input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
	output logic [WIDTH-1:0]                         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end

endmodule
